/* sv/mpct_pkg.sv */
// Shared types, constants and helpers for the mouse packet cursor tracker.
package mpct_pkg;

  localparam int COORD_BITS = 12;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int SUM_BITS   = COORD_BITS + 2;
  localparam int MAX_EVENTS = 4;
  localparam int EV_IDX_BITS = $clog2(MAX_EVENTS);
  localparam int EV_CNT_BITS = $clog2(MAX_EVENTS + 1);
  localparam int CFG_IDX_BITS = 1;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);
  localparam logic [SIZE_BITS-1:0] SIZE_CAP     = SIZE_BITS'(1) << COORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [2:0] KIND_LEFT_DOWN   = 3'd0;
  localparam logic [2:0] KIND_LEFT_UP     = 3'd1;
  localparam logic [2:0] KIND_RIGHT_DOWN  = 3'd2;
  localparam logic [2:0] KIND_RIGHT_UP    = 3'd3;
  localparam logic [2:0] KIND_MIDDLE_DOWN = 3'd4;
  localparam logic [2:0] KIND_MIDDLE_UP   = 3'd5;
  localparam logic [2:0] KIND_MOVE        = 3'd6;

  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  typedef struct packed {
    logic [7:0]        status_byte;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            event_kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  last_event;
  } out_item_t;

  typedef struct packed {
    out_item_t [MAX_EVENTS-1:0] ev;
    logic [EV_CNT_BITS-1:0]     count;
  } evt_list_t;

  function automatic logic [2:0] button_kind(input logic [1:0] btn, input logic up);
    logic [2:0] k;
    k = KIND_LEFT_DOWN;
    case (btn)
      BTN_LEFT:   k = up ? KIND_LEFT_UP : KIND_LEFT_DOWN;
      BTN_RIGHT:  k = up ? KIND_RIGHT_UP : KIND_RIGHT_DOWN;
      BTN_MIDDLE: k = up ? KIND_MIDDLE_UP : KIND_MIDDLE_DOWN;
      default:    k = KIND_LEFT_DOWN;
    endcase
    return k;
  endfunction

endpackage

/* sv/mpct_event_gen.sv */
// Cursor and button state, and the event list built for one packet.
module mpct_event_gen import mpct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  in_item_t             item,
  input  logic [SIZE_BITS-1:0] window_width,
  input  logic [SIZE_BITS-1:0] window_height,
  output evt_list_t            list
);

  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [2:0]            prev_buttons;

  logic [COORD_BITS-1:0] nx, ny;
  logic signed [SUM_BITS-1:0] sum_x, sum_y;
  logic [COORD_BITS-1:0] top_x, top_y;
  out_item_t [MAX_EVENTS-1:0] cand;
  logic [MAX_EVENTS-1:0]      cand_v;
  logic [EV_CNT_BITS-1:0]     n;
  logic [EV_CNT_BITS-1:0]     n_m1;

  function automatic logic [COORD_BITS-1:0] size_top(input logic [SIZE_BITS-1:0] size);
    logic [COORD_BITS-1:0] t;
    if (size == '0) begin
      t = '0;
    end else if (size > SIZE_CAP) begin
      t = '1;
    end else begin
      t = COORD_BITS'(size - SIZE_BITS'(1));
    end
    return t;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_BITS-1:0] v,
                                                  input logic [COORD_BITS-1:0] top);
    logic [COORD_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, top})) begin
      r = top;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    top_x = size_top(window_width);
    top_y = size_top(window_height);
    sum_x = $signed({2'b00, cursor_x}) + SUM_BITS'(item.delta_x);
    sum_y = $signed({2'b00, cursor_y}) - SUM_BITS'(item.delta_y);
    nx = clamp(sum_x, top_x);
    ny = clamp(sum_y, top_y);

    for (int i = 0; i < 3; i++) begin
      cand_v[i] = item.status_byte[i] ^ prev_buttons[i];
      cand[i].event_kind = button_kind(2'(i), prev_buttons[i]);
      cand[i].pos_x = cursor_x;
      cand[i].pos_y = cursor_y;
      cand[i].last_event = 1'b0;
    end
    cand_v[3] = (nx != cursor_x) || (ny != cursor_y);
    cand[3].event_kind = KIND_MOVE;
    cand[3].pos_x = nx;
    cand[3].pos_y = ny;
    cand[3].last_event = 1'b0;

    list = '0;
    n = '0;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      if (cand_v[i]) begin
        list.ev[n[EV_IDX_BITS-1:0]] = cand[i];
        n = n + EV_CNT_BITS'(1);
      end
    end
    n_m1 = n - EV_CNT_BITS'(1);
    if (n != '0) begin
      list.ev[n_m1[EV_IDX_BITS-1:0]].last_event = 1'b1;
    end
    list.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      prev_buttons <= '0;
    end else if (take) begin
      cursor_x     <= nx;
      cursor_y     <= ny;
      prev_buttons <= item.status_byte[2:0];
    end
  end

endmodule

/* sv/mpct_event_queue.sv */
// Result buffer that holds one packet's events and hands them out in order.
module mpct_event_queue import mpct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  evt_list_t list,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  out_item_t [MAX_EVENTS-1:0] ev;
  logic [EV_CNT_BITS-1:0]     cnt;
  logic [EV_IDX_BITS-1:0]     idx;
  logic                       busy;
  logic                       fire;

  assign out_valid = busy;
  assign out_item  = ev[idx];
  assign fire      = busy && !out_stall;
  assign free      = !busy || (fire && ev[idx].last_event);

  always_ff @(posedge clk) begin
    if (load) begin
      ev <= list.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      cnt  <= '0;
    end else if (load) begin
      busy <= (list.count != '0);
      idx  <= '0;
      cnt  <= list.count;
    end else if (fire) begin
      if (ev[idx].last_event) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + EV_IDX_BITS'(1);
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < cnt))
    else $error("event index past count");

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    busy |-> (ev[idx].last_event == (({1'b0, idx} + EV_CNT_BITS'(1)) == cnt)))
    else $error("last flag out of step with count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("load while events pending");

  a_keep_going: assert property (@(posedge clk) disable iff (rst)
    (fire && !ev[idx].last_event && !load) |=> busy)
    else $error("buffer dropped pending events");

endmodule

/* sv/mouse_packet_cursor_tracker_core.sv */
// Top level of the mouse packet cursor tracker.
//
// Usage: one PS/2 style packet (status byte, signed dx, signed dy) enters on
// in_item when in_valid is high and in_stall low. Each packet yields zero to
// four event items on out_item (button press/release in left, right, middle
// order, then a move event when the clamped position changed); last_event
// marks the final item of a packet. A packet with no change yields nothing.
// An accepted packet waits in the input register, is turned into events
// as it is loaded into the result buffer, and its first event is offered
// from there. The buffer hands out one event item per cycle while out_stall
// is low; a quiet packet never occupies it, and the input register takes
// the next packet while the buffer drains.
// Window size registers are written on cfg_we; write them only when idle.
// Reset clears the cursor to (0,0), all buttons released, window 640x480.
// When out_stall is high the current event holds; once the input register
// is full as well, in_stall rises.
module mouse_packet_cursor_tracker_core import mpct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]    cfg_data
);

  logic [SIZE_BITS-1:0] window_width;
  logic [SIZE_BITS-1:0] window_height;
  in_item_t             in_reg;
  logic                 in_full;
  logic                 in_full_next;
  logic                 take;
  logic                 accept;
  logic                 free;
  evt_list_t            list;

  assign take         = in_full && free;
  assign in_stall     = in_full && !free;
  assign accept       = in_valid && !in_stall;
  assign in_full_next = accept || (in_full && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_WIDTH:  window_width  <= cfg_data;
        CFG_WINDOW_HEIGHT: window_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_item;
    end
  end

  mpct_event_gen u_gen (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item          (in_reg),
    .window_width  (window_width),
    .window_height (window_height),
    .list          (list)
  );

  mpct_event_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .list      (list),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
